[sv/ircp_pkg.sv]
// ----------------------------------------------------------------------------
// ircp_pkg
// Shared types and constants for the IPv4 range to CIDR prefix expander.
// ----------------------------------------------------------------------------
`default_nettype none

package ircp_pkg;

  // Fixed widths of the transaction fields
  localparam int ADDR_W         = 32;
  localparam int LEN_W          = 6;
  localparam int ADDR_BITS_DEF  = 32;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMPTY
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_range;   // capture a valid range into cursor / remainder
    logic emit;         // emit the next prefix into the output register
    logic emit_empty;   // emit the single empty-range result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic reversed;     // input start exceeds input end
    logic last;         // current prefix covers the rest of the range
    logic out_free;     // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

[sv/ircp_ctrl.sv]
// ----------------------------------------------------------------------------
// ircp_ctrl
// Sequencer: accepts one range, steps the datapath once per prefix, or emits one empty result if reversed.
// ----------------------------------------------------------------------------
`default_nettype none

module ircp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire ircp_pkg::sts_t sts,
  output ircp_pkg::cmd_t      cmd
);
  import ircp_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = sts.reversed ? S_EMPTY : S_RUN;
        end
      end
      S_RUN: begin
        if (sts.out_free && sts.last) begin
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall       = 1'b0;
        cmd.load_range = in_valid && !sts.reversed;
      end
      S_RUN: begin
        cmd.emit = sts.out_free;
      end
      S_EMPTY: begin
        cmd.emit_empty = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Checks
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_empty) |-> sts.out_free)
    else $error("result emitted while output register is held");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && sts.last) |=> state == S_IDLE)
    else $error("run did not end after final prefix");

  a_accept_only_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && $past(state) == S_IDLE) |-> $past(in_valid) && !$past(sts.reversed))
    else $error("run started without a valid forward range");

endmodule

`default_nettype wire

[sv/ircp_dp.sv]
// ----------------------------------------------------------------------------
// ircp_dp
// Datapath: cursor, remaining count, block-size select, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ircp_dp #(
  parameter int ADDRESS_BITS = ircp_pkg::ADDR_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [ircp_pkg::ADDR_W-1:0]  range_start,
  input  wire logic [ircp_pkg::ADDR_W-1:0]  range_end,
  input  wire ircp_pkg::cmd_t               cmd,
  output ircp_pkg::sts_t                    sts,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ircp_pkg::ADDR_W-1:0]       prefix_base,
  output logic [ircp_pkg::LEN_W-1:0]        prefix_length,
  output logic                              last_prefix,
  output logic                              empty_range
);
  import ircp_pkg::*;

  localparam int AB = ADDRESS_BITS;
  localparam int JW = $clog2(AB + 1);

  logic [AB-1:0] start_m;
  logic [AB-1:0] end_m;
  logic [AB-1:0] cursor;
  logic [AB:0]   rem;        // addresses still to cover, 1 .. 2^AB
  logic [AB:0]   tz_vec;
  logic [AB:0]   tz_oh;      // lowest set bit of cursor, capped at AB
  logic [AB:0]   rem_rev;
  logic [AB:0]   rem_rev_low;
  logic [AB:0]   msb_oh;     // highest set bit of remaining count
  logic [AB:0]   step_oh;    // chosen block size, one-hot
  logic [JW-1:0] step_idx;

  assign start_m = range_start[AB-1:0];
  assign end_m   = range_end[AB-1:0];

  // Alignment limit: isolate lowest set bit, forced bit AB caps the count
  assign tz_vec = {1'b1, cursor};
  assign tz_oh  = tz_vec & (~tz_vec + 1'b1);

  // Size limit: isolate highest set bit of the remaining count
  always_comb begin
    for (int i = 0; i <= AB; i++) begin
      rem_rev[i] = rem[AB - i];
    end
  end
  assign rem_rev_low = rem_rev & (~rem_rev + 1'b1);
  always_comb begin
    for (int i = 0; i <= AB; i++) begin
      msb_oh[i] = rem_rev_low[AB - i];
    end
  end

  // Block size is the smaller of the two limits
  assign step_oh = (tz_oh < msb_oh) ? tz_oh : msb_oh;

  // log2 of the block size
  always_comb begin
    step_idx = '0;
    for (int i = 0; i <= AB; i++) begin
      if (step_oh[i]) begin
        step_idx = step_idx | JW'(i);
      end
    end
  end

  // Status
  assign sts.reversed = start_m > end_m;
  assign sts.last     = (rem == step_oh);
  assign sts.out_free = !out_valid || !out_stall;

  // Cursor and remaining count
  always_ff @(posedge clk) begin
    if (cmd.load_range) begin
      cursor <= start_m;
      rem    <= {1'b0, end_m} - {1'b0, start_m} + 1'b1;
    end else if (cmd.emit) begin
      cursor <= cursor + step_oh[AB-1:0];
      rem    <= rem - step_oh;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      prefix_base   <= ADDR_W'(cursor);
      prefix_length <= LEN_W'(AB) - LEN_W'(step_idx);
      last_prefix   <= sts.last;
      empty_range   <= 1'b0;
    end else if (cmd.emit_empty) begin
      prefix_base   <= '0;
      prefix_length <= '0;
      last_prefix   <= 1'b0;
      empty_range   <= 1'b1;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Checks
  a_step_onehot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $onehot(step_oh) && rem != '0)
    else $error("block size not a single power of two");

  a_empty_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_range) |-> prefix_base == '0 && prefix_length == '0 && !last_prefix)
    else $error("empty-range result carries nonzero fields");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !empty_range) |-> prefix_length <= LEN_W'(AB))
    else $error("prefix length beyond address width");

endmodule

`default_nettype wire

[sv/ipv4_range_to_cidr_prefixes.sv]
// An accepted range is loaded into the cursor and remaining count; its prefixes then
// enter the output register, one prefix per cycle while out_stall is low, set by the
// cursor update loop. No new range is taken until the last prefix has been emitted.
// A reversed range yields one empty result.
// Reset (rst, synchronous) returns the sequencer to idle and clears out_valid.
// ----------------------------------------------------------------------------
// ipv4_range_to_cidr_prefixes
// Expands an inclusive IPv4 range into the minimal ascending CIDR block list.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_range_to_cidr_prefixes #(
  parameter int ADDRESS_BITS = ircp_pkg::ADDR_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ircp_pkg::ADDR_W-1:0]  range_start,
  input  wire logic [ircp_pkg::ADDR_W-1:0]  range_end,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [ircp_pkg::ADDR_W-1:0]       prefix_base,
  output logic [ircp_pkg::LEN_W-1:0]        prefix_length,
  output logic                              last_prefix,
  output logic                              empty_range
);
  import ircp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  ircp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  ircp_dp #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .range_start   (range_start),
    .range_end     (range_end),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .prefix_base   (prefix_base),
    .prefix_length (prefix_length),
    .last_prefix   (last_prefix),
    .empty_range   (empty_range)
  );

endmodule

`default_nettype wire

[test/ipv4_range_to_cidr_prefixes_tb.sv]
// ----------------------------------------------------------------------------
// ipv4_range_to_cidr_prefixes_tb
// Self-checking bench for the IPv4 range to CIDR prefix expander. Ranges are
// sent through the valid/stall input channel. A behavioral expansion of each
// accepted range queues the prefixes it should produce, and every output
// transaction is checked field by field against the oldest queued prefix.
// Sender gaps and receiver stalls are randomized in two phases, then off in a third.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_range_to_cidr_prefixes_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ircp_pkg::*;

  localparam int ADDRESS_BITS = 32;
  localparam int MAX_PREFIXES = 62;
  localparam int IDLE_LIMIT   = 4000;   // cycles without any transaction
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PER_PHASE = 100;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic              empty;
  } cidr_prefix_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ADDR_W-1:0] range_start = '0;
  logic [ADDR_W-1:0] range_end = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] prefix_base;
  logic [LEN_W-1:0]  prefix_length;
  logic              last_prefix;
  logic              empty_range;

  cidr_prefix_t pending_prefixes[$];
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           ranges_sent    = 0;
  int           reversed_sent  = 0;
  int           prefixes_seen  = 0;
  int           mismatches     = 0;
  int           quiet_cycles   = 0;

  ipv4_range_to_cidr_prefixes #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .range_start   (range_start),
    .range_end     (range_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .prefix_base   (prefix_base),
    .prefix_length (prefix_length),
    .last_prefix   (last_prefix),
    .empty_range   (empty_range)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Expand one range into its ascending list of aligned blocks
  task automatic expand_range(input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] final_addr);
    logic [ADDR_W:0] cur;
    logic [ADDR_W:0] top;
    logic [ADDR_W:0] stop;
    cidr_prefix_t    p;
    int              tz;
    int              j;
    int              count;
    bit              done;
    stop = {1'b0, final_addr};
    if (first > final_addr) begin
      p = '{base: '0, len: '0, last: 1'b0, empty: 1'b1};
      pending_prefixes.push_back(p);
      reversed_sent++;
    end else begin
      cur   = {1'b0, first};
      done  = 1'b0;
      count = 0;
      while (!done && count < MAX_PREFIXES) begin
        // trailing zeros, capped at the address width
        tz = 0;
        while (tz < ADDRESS_BITS && cur[tz] == 1'b0) tz++;
        // shrink the block until it stays inside the range
        j = tz;
        while (j > 0 && (cur | ((33'd1 << j) - 33'd1)) > stop) j--;
        top = cur | ((33'd1 << j) - 33'd1);
        p.base  = cur[ADDR_W-1:0];
        p.len   = LEN_W'(ADDRESS_BITS - j);
        p.last  = (top >= stop);
        p.empty = 1'b0;
        pending_prefixes.push_back(p);
        count++;
        cur = top + 33'd1;
        if (top >= stop) done = 1'b1;
      end
    end
  endtask

  // Drive one range transaction; returns after it is accepted
  task automatic send_range(input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] final_addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    range_start <= first;
    range_end   <= final_addr;
    do @(posedge clk); while (in_stall);
    ranges_sent++;
    expand_range(first, final_addr);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    cidr_prefix_t want;
    if (!rst && out_valid && !out_stall) begin
      prefixes_seen++;
      if (pending_prefixes.size() == 0) begin
        $error("unexpected prefix: base %h length %0d last %0b empty %0b",
               prefix_base, prefix_length, last_prefix, empty_range);
        mismatches++;
      end else begin
        want = pending_prefixes.pop_front();
        if (prefix_base !== want.base) begin
          $error("prefix_base: expected %h, actual %h", want.base, prefix_base);
          mismatches++;
        end
        if (prefix_length !== want.len) begin
          $error("prefix_length: expected %0d, actual %0d", want.len, prefix_length);
          mismatches++;
        end
        if (last_prefix !== want.last) begin
          $error("last_prefix: expected %0b, actual %0b", want.last, last_prefix);
          mismatches++;
        end
        if (empty_range !== want.empty) begin
          $error("empty_range: expected %0b, actual %0b", want.empty, empty_range);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d prefixes outstanding",
               IDLE_LIMIT, pending_prefixes.size());
      $display("** ipv4_range_to_cidr_prefixes: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Address extremes and whole-space ranges
  task automatic test_boundary_ranges();
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'hFFFF_FFFF);   // single /0 from cursor zero
    send_range(32'h8000_0000, 32'hFFFF_FFFF);   // reaches the top address
    send_range(32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'h7FFF_FFFF);
    send_range(32'h0A00_0000, 32'h0A00_00FF);   // one aligned /24
    send_range(32'h0A00_0001, 32'h0A00_00FE);
    send_range(32'h0000_0005, 32'h0000_0005);
    send_range(32'h5555_5555, 32'hAAAA_AAAA);
    send_range(32'hC0A8_0001, 32'hC0A8_0102);
  endtask

  // Start above end: one empty result each
  task automatic test_reversed_ranges();
    send_range(32'h0000_0001, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_range(32'hAAAA_AAAA, 32'h5555_5555);
    send_range(32'h1234_5679, 32'h1234_5678);
  endtask

  // Ranges that split into many blocks; 0000_0001 to FFFF_FFFE gives the largest number
  task automatic test_worst_case_fragmentation();
    send_range(32'h0000_0001, 32'hFFFF_FFFE);
    send_range(32'h0000_0001, 32'hFFFF_FFFE);   // sent again straight after; sender gaps still apply
    send_range(32'h0000_0001, 32'h7FFF_FFFE);
    send_range(32'h8000_0001, 32'hFFFF_FFFE);
  endtask

  // Mostly well-formed ranges of varied size, with some noise and reversals
  task automatic test_random_ranges(input int n);
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] e;
    logic [ADDR_W:0]   sum;
    logic [ADDR_W-1:0] mask;
    int                k;
    repeat (n) begin
      s = $urandom;
      e = $urandom;
      case ($urandom_range(0, 9))
        0, 1: begin
          // independent endpoints, half of them reversed
        end
        2, 3: begin
          sum = {1'b0, s} + 33'($urandom_range(0, 300));
          e   = sum[ADDR_W] ? 32'hFFFF_FFFF : sum[ADDR_W-1:0];
        end
        4, 5: begin
          sum = {1'b0, s} + 33'($urandom >> $urandom_range(0, 31));
          e   = sum[ADDR_W] ? 32'hFFFF_FFFF : sum[ADDR_W-1:0];
        end
        6: begin
          s = ADDR_W'($urandom_range(0, 15));
        end
        7: begin
          e = 32'hFFFF_FFFF - ADDR_W'($urandom_range(0, 15));
          s = e - ($urandom >> $urandom_range(0, 31));
        end
        8: begin
          // exactly one aligned block of random size
          k    = $urandom_range(0, ADDRESS_BITS);
          mask = (k == ADDRESS_BITS) ? 32'hFFFF_FFFF : ((32'd1 << k) - 32'd1);
          s    = s & ~mask;
          e    = s | mask;
        end
        default: begin
          // reversed by a small margin
          if (s < 32'd1000) s = s + 32'd1000;
          e = s - 32'd1 - ADDR_W'($urandom_range(0, 900));
        end
      endcase
      send_range(s, e);
    end
  endtask

  // Main sequence
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase 1: sender gaps 24 %, receiver stalls 46 %
    send_idle_pct  = 24;
    recv_stall_pct = 46;
    test_boundary_ranges();
    test_reversed_ranges();
    test_worst_case_fragmentation();
    test_random_ranges(RANDOM_PER_PHASE);

    // Phase 2: roles swapped
    send_idle_pct  = 46;
    recv_stall_pct = 24;
    test_random_ranges(RANDOM_PER_PHASE);

    // Phase 3: full rate on both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_worst_case_fragmentation();
    test_random_ranges(RANDOM_PER_PHASE);

    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_prefixes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Expanded %0d ranges (%0d reversed) into %0d checked prefixes,",
             ranges_sent, reversed_sent, prefixes_seen);
    $display("under random sender gaps and receiver stalls and at full rate; %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_prefixes.size() == 0) begin
      $display("** ipv4_range_to_cidr_prefixes: PASSED **");
    end else begin
      $display("** ipv4_range_to_cidr_prefixes: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
